// ===== hdl/flc_pkg.sv =====
package flc_pkg;
  localparam int Entries = 64;
  localparam int HitBits = 16;
  localparam int AddrW = 48;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);
  localparam int CapW = 7;
  localparam int StampW = 32;
  localparam logic [CapW-1:0] CapReset = CapW'(64);

  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] tag;
    logic             dirty;
    logic             freq;
    logic [HitBits-1:0] hits;
    logic [StampW-1:0]  stamp;
  } entry_t;
endpackage

// ===== hdl/flc_cell.sv =====
module flc_cell
  import flc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift,
  input  entry_t d_in,
  input  logic   wr_en,
  input  entry_t wr_data,
  output entry_t q
);
  entry_t q_r, q_nxt;
  always_comb begin
    q_nxt = q_r;
    if (wr_en) begin
      q_nxt = wr_data;
    end else if (shift) begin
      q_nxt = d_in;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r.valid <= q_nxt.valid;
    end
    q_r.tag   <= q_nxt.tag;
    q_r.dirty <= q_nxt.dirty;
    q_r.freq  <= q_nxt.freq;
    q_r.hits  <= q_nxt.hits;
    q_r.stamp <= q_nxt.stamp;
  end
  assign q = q_r;
endmodule

// ===== hdl/fifo_lfu_cache_replacement.sv =====
// Flow per input: a scan over one full ring turn (S_SCAN), a decide step (S_DEC), a write back
// over one full ring turn (S_WB) and a present step (S_OUT) that registers the result.
// A new input is taken only in S_IDLE; the next input is taken while a result waits, and a
// second finished result holds until the first is transferred.
// Reset (rst_n low, synchronous): all entries invalid, counters zero,
// capacity 64, no result pending.
module fifo_lfu_cache_replacement
  import flc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [AddrW-1:0] in_block_address,
  input  logic             in_mode,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_hit,
  output logic             out_evicted,
  output logic [AddrW-1:0] out_evicted_address,
  output logic             out_evicted_dirty,
  input  logic             cfg_we,
  input  logic [CapW-1:0]  cfg_wdata
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [CapW-1:0] cap_r;
  logic [StampW-1:0] ctr_r;
  logic [CntW-1:0] res_r, fifo_r;
  logic [IdxW-1:0] pos_r;
  logic [AddrW-1:0] addr_r;
  logic wr_r;
  logic hitf_r, fv_r, lv_r, fe_r;
  logic [IdxW-1:0] hidx_r, fidx_r, lidx_r, eidx_r, tgt_r;
  logic [StampW-1:0] fage_r, lage_r;
  logic [HitBits-1:0] lhits_r;
  logic ehit_r, eev_r, edirty_r, fdirty_r;
  logic [AddrW-1:0] eaddr_r, faddr_r;
  logic ins_r, upd_r;
  logic o_hit_r, o_ev_r, o_dirty_r, ov_r;
  logic [AddrW-1:0] o_addr_r;

  entry_t q [Entries];
  logic shift;
  logic wr_en;
  entry_t wr_data;

  assign shift = (st_r == S_SCAN) || (st_r == S_WB);
  logic [IdxW-1:0] cur;
  assign cur = pos_r;

  genvar g;
  generate
    for (g = 0; g < Entries; g++) begin : g_cell
      flc_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift(shift),
        .d_in(q[(g + 1) % Entries]),
        .wr_en(g == Entries - 1 ? wr_en : 1'b0), .wr_data(wr_data), .q(q[g])
      );
    end
  endgenerate

  // Cell 0 holds slot cur (ring rotates toward cell 0).
  entry_t h;
  assign h = q[0];
  logic [StampW-1:0] hage;
  assign hage = ctr_r - h.stamp;

  logic [CapW-1:0] capc;
  always_comb begin
    capc = cap_r;
    if (cap_r == '0) capc = CapW'(1);
    if ({1'b0, cap_r} > (CapW+1)'(Entries)) capc = CapW'(Entries);
  end

  always_comb begin
    wr_en = 1'b0;
    wr_data = h;
    if (st_r == S_WB && cur == tgt_r) begin
      if (upd_r) begin
        wr_en = 1'b1;
        if (!h.freq) begin
          wr_data.freq = 1'b1;
          wr_data.stamp = ctr_r;
        end
        if (h.hits != '1) wr_data.hits = h.hits + 1'b1;
        if (wr_r) wr_data.dirty = 1'b1;
      end else if (ins_r) begin
        wr_en = 1'b1;
        wr_data.valid = 1'b1;
        wr_data.tag = addr_r;
        wr_data.dirty = wr_r;
        wr_data.freq = 1'b0;
        wr_data.hits = '0;
        wr_data.stamp = ctr_r;
      end
    end
  end

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_hit = o_hit_r;
  assign out_evicted = o_ev_r;
  assign out_evicted_address = o_addr_r;
  assign out_evicted_dirty = o_dirty_r;

  logic last;
  assign last = pos_r == IdxW'(Entries - 1);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_valid && in_ready) st_nxt = S_SCAN;
      S_SCAN: if (last) st_nxt = S_DEC;
      S_DEC:  st_nxt = S_WB;
      S_WB:   if (last) st_nxt = S_OUT;
      S_OUT:  if (!ov_r || out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cap_r <= CapReset;
      ctr_r <= '0;
      res_r <= '0;
      fifo_r <= '0;
      pos_r <= '0;
      ov_r <= 1'b0;
      ins_r <= 1'b0;
      upd_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          pos_r <= '0;
          if (in_valid && in_ready) begin
            addr_r <= in_block_address;
            wr_r <= in_mode;
            hitf_r <= 1'b0;
            fv_r <= 1'b0;
            lv_r <= 1'b0;
            fe_r <= 1'b0;
          end
        end
        S_SCAN: begin
          pos_r <= pos_r + 1'b1;
          if (h.valid && h.tag == addr_r && !hitf_r) begin
            hitf_r <= 1'b1;
            hidx_r <= cur;
          end
          if (!h.valid && !fe_r) begin
            fe_r <= 1'b1;
            fidx_r <= cur;
          end
          if (h.valid && !h.freq && (!fv_r || hage > fage_r)) begin
            fv_r <= 1'b1;
            fage_r <= hage;
            eidx_r <= cur;
            faddr_r <= h.tag;
            fdirty_r <= h.dirty;
          end
          if (h.valid && h.freq && (!lv_r || h.hits < lhits_r ||
              (h.hits == lhits_r && hage > lage_r))) begin
            lv_r <= 1'b1;
            lidx_r <= cur;
            lhits_r <= h.hits;
            lage_r <= hage;
            eaddr_r <= h.tag;
            edirty_r <= h.dirty;
          end
        end
        S_DEC: begin
          upd_r <= 1'b0;
          ins_r <= 1'b0;
          ehit_r <= hitf_r;
          eev_r <= 1'b0;
          if (hitf_r) begin
            upd_r <= 1'b1;
            tgt_r <= hidx_r;
          end else if ({1'b0, res_r} >= (CntW+1)'(capc) && (fv_r && fifo_r != '0)) begin
            ins_r <= 1'b1; eev_r <= 1'b1; tgt_r <= eidx_r;
            eaddr_r <= faddr_r; edirty_r <= fdirty_r;
            fifo_r <= fifo_r - 1'b1;
            res_r <= res_r - 1'b1;
          end else if ({1'b0, res_r} >= (CntW+1)'(capc) && lv_r) begin
            ins_r <= 1'b1; eev_r <= 1'b1; tgt_r <= lidx_r;
            res_r <= res_r - 1'b1;
          end else if (fe_r) begin
            ins_r <= 1'b1; tgt_r <= fidx_r;
          end
        end
        S_WB: begin
          pos_r <= pos_r + 1'b1;
          if (wr_en && upd_r && !h.freq) begin
            ctr_r <= ctr_r + 1'b1;
            if (fifo_r != '0) fifo_r <= fifo_r - 1'b1;
          end
          if (wr_en && ins_r) begin
            ctr_r <= ctr_r + 1'b1;
            res_r <= res_r + 1'b1;
            fifo_r <= fifo_r + 1'b1;
          end
        end
        S_OUT: begin
          if (!ov_r || out_ready) begin
            ov_r <= 1'b1;
            o_hit_r <= ehit_r;
            o_ev_r <= eev_r;
            o_addr_r <= eev_r ? eaddr_r : '0;
            o_dirty_r <= eev_r && edirty_r;
          end
        end
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == S_IDLE) else $error("ready outside idle");
  a_hit_no_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted)) else $error("hit with eviction");
  a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_r <= res_r) else $error("fifo count above resident count");
endmodule
